@@ rtl/core/pso_pkg.sv @@
// ---------------------------------------------------------------------------
// pso_pkg
// Types and constants shared by the shape overlay cells and the top level.
// ---------------------------------------------------------------------------
`default_nettype none

package pso_pkg;

   localparam int CountWidth = 4;
   localparam int CoordWidth = 8;
   localparam int StyleWidth = 8;
   localparam int FormWidth  = 2;
   localparam int SlotWidth  = 3;

   localparam logic [StyleWidth-1:0] BG_STYLE = 8'd126;

   localparam logic [FormWidth-1:0] FORM_OFF     = 2'd0;
   localparam logic [FormWidth-1:0] FORM_DIAMOND = 2'd1;
   localparam logic [FormWidth-1:0] FORM_CIRCLE  = 2'd2;

   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_PIXEL = 1'b1;

   localparam int REG_SHAPE_COUNT = 0;

   // item travelling down the cell chain
   typedef struct packed {
      logic                  valid;
      logic                  req_type;
      logic [SlotWidth-1:0]  slot;
      logic [CoordWidth-1:0] pos_x;
      logic [CoordWidth-1:0] pos_y;
      logic [CoordWidth-1:0] radius;
      logic [StyleWidth-1:0] style;
      logic [FormWidth-1:0]  form;
      logic                  found;
      logic [StyleWidth-1:0] style_res;
   } link_type;

endpackage

`default_nettype wire

@@ rtl/core/pso_cell.sv @@
// ---------------------------------------------------------------------------
// pso_cell
// One table slot of the overlay: stores a shape, tests passing pixels
// against it and hands every item on to the next cell.
// ---------------------------------------------------------------------------
`default_nettype none

module pso_cell #(
   parameter int CELL_INDEX = 0
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             advance,
   input  wire logic [pso_pkg::CountWidth-1:0]   shape_count,
   input  wire pso_pkg::link_type                link_in,
   output pso_pkg::link_type                     link_out
);
   import pso_pkg::*;

   logic [CoordWidth-1:0]   cx_ff, cy_ff, rad_ff;
   logic [2*CoordWidth-1:0] rad_sq_ff;
   logic [StyleWidth-1:0]   sty_ff;
   logic [FormWidth-1:0]    form_ff;
   link_type                link_ff, link_in_next;

   logic [CoordWidth-1:0]   dx, dy;
   logic [CoordWidth:0]     l1;
   logic [2*CoordWidth-1:0] dx_sq, dy_sq;
   logic [2*CoordWidth:0]   l2_sq;
   logic                    in_range, covers, load;

   always_comb begin
      dx = (link_in.pos_x >= cx_ff) ? (link_in.pos_x - cx_ff) : (cx_ff - link_in.pos_x);
      dy = (link_in.pos_y >= cy_ff) ? (link_in.pos_y - cy_ff) : (cy_ff - link_in.pos_y);
      l1    = {1'b0, dx} + {1'b0, dy};
      dx_sq = dx * dx;
      dy_sq = dy * dy;
      l2_sq = {1'b0, dx_sq} + {1'b0, dy_sq};
      in_range = int'(shape_count) > CELL_INDEX;
      case (form_ff)
         FORM_DIAMOND: covers = l1 <= {1'b0, rad_ff};
         FORM_CIRCLE:  covers = l2_sq <= {1'b0, rad_sq_ff};
         default:      covers = 1'b0;
      endcase
      load = link_in.valid && (link_in.req_type == REQ_WRITE)
             && (int'(link_in.slot) == CELL_INDEX);

      link_in_next = link_in;
      // first covering slot wins
      if (link_in.valid && (link_in.req_type == REQ_PIXEL) && !link_in.found
          && in_range && covers) begin
         link_in_next.found     = 1'b1;
         link_in_next.style_res = sty_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         form_ff <= FORM_OFF;
         link_ff <= '0;
      end else if (advance) begin
         link_ff <= link_in_next;
         if (load) begin
            form_ff <= link_in.form;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && load) begin
         cx_ff     <= link_in.pos_x;
         cy_ff     <= link_in.pos_y;
         rad_ff    <= link_in.radius;
         rad_sq_ff <= link_in.radius * link_in.radius;
         sty_ff    <= link_in.style;
      end
   end

   assign link_out = link_ff;

endmodule

`default_nettype wire

@@ rtl/core/priority_shape_overlay.sv @@
// ---------------------------------------------------------------------------
// priority_shape_overlay
// Priority overlay of a small table of diamond and circle shapes.
// ---------------------------------------------------------------------------
// Usage:
//   req_ channel: a transfer with req_type 0 loads table slot req_slot with
//   a shape; req_type 1 asks about pixel (req_pos_x, req_pos_y).
//   rsp_ channel: one transfer per pixel item, none per write item. rsp_hit
//   tells whether a shape covers the pixel, rsp_style_out gives the style of
//   the first covering slot below shape_count, else the background code 126.
//   shape_count sits at byte address 0 of the APB port.
// Pipeline:
//   the table is a chain of MAX_SHAPES cells, one per slot; every item walks
//   the chain one cell per cycle while the chain is not frozen, and a pixel's
//   result is registered once more after the last cell. One item is taken per cycle
//   while req_ready is high, writes included, so a write lands in program order between the pixels around it.
// Reset clears shape_count and disables every slot; no clearing pass.
// A stalled rsp_ready freezes the whole chain and drops req_ready until the
// waiting result is taken.
// ---------------------------------------------------------------------------
`default_nettype none

module priority_shape_overlay #(
   parameter int MAX_SHAPES = 8
) (
   input  wire logic                            clock,
   input  wire logic                            reset,

   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic                            req_type,
   input  wire logic [pso_pkg::SlotWidth-1:0]   req_slot,
   input  wire logic [pso_pkg::CoordWidth-1:0]  req_pos_x,
   input  wire logic [pso_pkg::CoordWidth-1:0]  req_pos_y,
   input  wire logic [pso_pkg::CoordWidth-1:0]  req_radius,
   input  wire logic [pso_pkg::StyleWidth-1:0]  req_style,
   input  wire logic [pso_pkg::FormWidth-1:0]   req_form,

   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic                                 rsp_hit,
   output logic [pso_pkg::StyleWidth-1:0]       rsp_style_out,

   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [2:0]                      paddr,
   input  wire logic [31:0]                     pwdata,
   output logic [31:0]                          prdata,
   output logic                                 pready
);
   import pso_pkg::*;

   logic [CountWidth-1:0]  shape_count_ff;
   logic                   rsp_valid_ff;
   logic                   rsp_hit_ff;
   logic [StyleWidth-1:0]  rsp_style_ff;
   logic                   advance;
   logic                   reg_sel;
   link_type               links [0:MAX_SHAPES];
   link_type               tail;

   // register index from the word address
   assign reg_sel = (int'(paddr[2]) == REG_SHAPE_COUNT);
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         shape_count_ff <= '0;
      end else if (psel && penable && pwrite && pready && reg_sel) begin
         shape_count_ff <= pwdata[CountWidth-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (reg_sel) begin
         prdata = {{(32-CountWidth){1'b0}}, shape_count_ff};
      end
   end

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   always_comb begin
      links[0].valid     = req_valid;
      links[0].req_type  = req_type;
      links[0].slot      = req_slot;
      links[0].pos_x     = req_pos_x;
      links[0].pos_y     = req_pos_y;
      links[0].radius    = req_radius;
      links[0].style     = req_style;
      links[0].form      = req_form;
      links[0].found     = 1'b0;
      links[0].style_res = BG_STYLE;
   end

   for (genvar g = 0; g < MAX_SHAPES; g++) begin : g_cell
      pso_cell #(
         .CELL_INDEX (g)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .advance     (advance),
         .shape_count (shape_count_ff),
         .link_in     (links[g]),
         .link_out    (links[g+1])
      );
   end

   assign tail = links[MAX_SHAPES];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= tail.valid && (tail.req_type == REQ_PIXEL);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_hit_ff   <= tail.found;
         rsp_style_ff <= tail.style_res;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_hit       = rsp_hit_ff;
   assign rsp_style_out = rsp_style_ff;

   // a miss always carries the background style
   a_miss_background: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_hit_ff |-> rsp_style_ff == BG_STYLE)
      else $error("miss without background style");

   // only pixel items leaving the chain become results
   a_pixel_only: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff == $past(tail.valid && (tail.req_type == REQ_PIXEL)))
      else $error("result does not match chain tail");

   // nothing is offered right after reset
   a_reset_empty: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid_ff)
      else $error("result valid after reset");

endmodule

`default_nettype wire

@@ tb/overlay_checker.sv @@
// ---------------------------------------------------------------------------
// overlay_checker
// Watches the request, result and APB ports of the shape overlay. It keeps
// its own copy of the shape table and of shape_count, works out the hit and
// style of every pixel transfer and compares them in order with the results.
// ---------------------------------------------------------------------------
module overlay_checker #(
   parameter int MAX_SHAPES = 8
) (
   input  logic                               clock,
   input  logic                               reset,

   input  logic                               req_valid,
   input  logic                               req_ready,
   input  logic                               req_type,
   input  logic [pso_pkg::SlotWidth-1:0]      req_slot,
   input  logic [pso_pkg::CoordWidth-1:0]     req_pos_x,
   input  logic [pso_pkg::CoordWidth-1:0]     req_pos_y,
   input  logic [pso_pkg::CoordWidth-1:0]     req_radius,
   input  logic [pso_pkg::StyleWidth-1:0]     req_style,
   input  logic [pso_pkg::FormWidth-1:0]      req_form,

   input  logic                               rsp_valid,
   input  logic                               rsp_ready,
   input  logic                               rsp_hit,
   input  logic [pso_pkg::StyleWidth-1:0]     rsp_style_out,

   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [2:0]                         paddr,
   input  logic [31:0]                        pwdata,
   input  logic                               pready,

   output int                                 mismatches,
   output int                                 outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   import pso_pkg::*;

   typedef struct packed {
      logic [CoordWidth-1:0] cx;
      logic [CoordWidth-1:0] cy;
      logic [CoordWidth-1:0] rad;
      logic [StyleWidth-1:0] sty;
      logic [FormWidth-1:0]  form;
   } shape_type;

   typedef struct packed {
      logic                  hit;
      logic [StyleWidth-1:0] style;
   } pixel_result_type;

   shape_type             shape_slots [MAX_SHAPES];
   logic [CountWidth-1:0] shape_count;
   pixel_result_type      expected_pixels [$];

   function automatic pixel_result_type overlay_lookup(input logic [CoordWidth-1:0] px,
                                                       input logic [CoordWidth-1:0] py);
      pixel_result_type res;
      int               dx;
      int               dy;
      int               r;
      int               n;
      bit               covered;
      res.hit   = 1'b0;
      res.style = BG_STYLE;
      n = (shape_count > MAX_SHAPES) ? MAX_SHAPES : int'(shape_count);
      // walk downward so the lowest covering slot wins
      for (int k = n - 1; k >= 0; k--) begin
         dx = (px >= shape_slots[k].cx) ? px - shape_slots[k].cx : shape_slots[k].cx - px;
         dy = (py >= shape_slots[k].cy) ? py - shape_slots[k].cy : shape_slots[k].cy - py;
         r  = shape_slots[k].rad;
         case (shape_slots[k].form)
            FORM_DIAMOND: covered = (dx + dy) <= r;
            FORM_CIRCLE:  covered = (dx * dx + dy * dy) <= r * r;
            default:      covered = 1'b0;
         endcase
         if (covered) begin
            res.hit   = 1'b1;
            res.style = shape_slots[k].sty;
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin : watch
      pixel_result_type want;
      if (reset) begin
         for (int i = 0; i < MAX_SHAPES; i++) begin
            shape_slots[i] = '0;
         end
         shape_count = '0;
         expected_pixels.delete();
         mismatches = 0;
      end else begin
         if (psel && penable && pwrite && pready && paddr == 3'(4 * REG_SHAPE_COUNT)) begin
            shape_count = pwdata[CountWidth-1:0];
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_pixels.size() == 0) begin
               $error("result transfer with nothing expected: hit %0d style_out %0d",
                      rsp_hit, rsp_style_out);
               mismatches++;
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_hit !== want.hit) begin
                  $error("hit: expected %0d, got %0d", want.hit, rsp_hit);
                  mismatches++;
               end
               if (rsp_style_out !== want.style) begin
                  $error("style_out: expected %0d, got %0d", want.style, rsp_style_out);
                  mismatches++;
               end
            end
         end
         if (req_valid && req_ready) begin
            if (req_type == REQ_WRITE) begin
               if (req_slot < MAX_SHAPES) begin
                  shape_slots[req_slot] = '{cx: req_pos_x, cy: req_pos_y, rad: req_radius,
                                            sty: req_style, form: req_form};
               end
            end else begin
               expected_pixels.push_back(overlay_lookup(req_pos_x, req_pos_y));
            end
         end
      end
      outstanding = expected_pixels.size();
   end

endmodule

@@ tb/tb_top.sv @@
// ---------------------------------------------------------------------------
// tb_top
// Stimulus for the shape overlay: directed shapes and pixels around the edge
// cases, then phases of random writes and pixels under several shape counts,
// with random stalls on both channels. The checker does the comparing.
// ---------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import pso_pkg::*;

   localparam int                  MAX_SHAPES    = 8;
   localparam int                  LATENCY       = MAX_SHAPES + 1;
   localparam int                  CYCLE_LIMIT   = 1000000;
   localparam logic [FormWidth-1:0] FORM_RESERVED = 2'd3;

   logic                  clock         = 1'b0;
   logic                  reset         = 1'b1;
   logic                  req_valid     = 1'b0;
   logic                  req_type      = REQ_WRITE;
   logic [SlotWidth-1:0]  req_slot      = '0;
   logic [CoordWidth-1:0] req_pos_x     = '0;
   logic [CoordWidth-1:0] req_pos_y     = '0;
   logic [CoordWidth-1:0] req_radius    = '0;
   logic [StyleWidth-1:0] req_style     = '0;
   logic [FormWidth-1:0]  req_form      = FORM_OFF;
   logic                  rsp_ready     = 1'b1;
   logic                  psel          = 1'b0;
   logic                  penable       = 1'b0;
   logic                  pwrite        = 1'b0;
   logic [2:0]            paddr         = '0;
   logic [31:0]           pwdata        = '0;
   logic                  req_ready;
   logic                  rsp_valid;
   logic                  rsp_hit;
   logic [StyleWidth-1:0] rsp_style_out;
   logic [31:0]           prdata;
   logic                  pready;

   int                    mismatches;
   int                    outstanding;
   int                    cycles        = 0;
   bit                    quiet         = 1'b0;

   // shapes written so far, used to aim pixels at them
   logic [CoordWidth-1:0] placed_x [MAX_SHAPES] = '{default: '0};
   logic [CoordWidth-1:0] placed_y [MAX_SHAPES] = '{default: '0};
   logic [CoordWidth-1:0] placed_r [MAX_SHAPES] = '{default: '0};

   priority_shape_overlay #(.MAX_SHAPES(MAX_SHAPES)) u_top (
      .clock, .reset,
      .req_valid, .req_ready, .req_type, .req_slot, .req_pos_x, .req_pos_y,
      .req_radius, .req_style, .req_form,
      .rsp_valid, .rsp_ready, .rsp_hit, .rsp_style_out,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   overlay_checker #(.MAX_SHAPES(MAX_SHAPES)) u_checker (
      .clock, .reset,
      .req_valid, .req_ready, .req_type, .req_slot, .req_pos_x, .req_pos_y,
      .req_radius, .req_style, .req_form,
      .rsp_valid, .rsp_ready, .rsp_hit, .rsp_style_out,
      .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
      .mismatches, .outstanding
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("priority_shape_overlay: mismatch");
         $finish;
      end
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // result side back-pressure
   initial begin : rsp_stall
      int gap;
      forever begin
         @(negedge clock);
         rsp_ready <= 1'b1;
         repeat ($urandom_range(0, 39)) @(negedge clock);
         gap = quiet ? 0 : pick_gap();
         if (gap > 0) begin
            @(negedge clock);
            rsp_ready <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
   end

   task automatic pause_req(input int n);
      if (n > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   task automatic send(input logic typ, input logic [SlotWidth-1:0] slot,
                       input logic [CoordWidth-1:0] x, input logic [CoordWidth-1:0] y,
                       input logic [CoordWidth-1:0] r, input logic [StyleWidth-1:0] s,
                       input logic [FormWidth-1:0] form);
      @(negedge clock);
      req_valid  <= 1'b1;
      req_type   <= typ;
      req_slot   <= slot;
      req_pos_x  <= x;
      req_pos_y  <= y;
      req_radius <= r;
      req_style  <= s;
      req_form   <= form;
      do @(posedge clock); while (!req_ready);
      if (typ == REQ_WRITE) begin
         placed_x[slot] = x;
         placed_y[slot] = y;
         placed_r[slot] = r;
      end
   endtask

   // pixel transfer; the fields a pixel ignores get random values
   task automatic probe(input logic [CoordWidth-1:0] x, input logic [CoordWidth-1:0] y);
      send(REQ_PIXEL, SlotWidth'($urandom), x, y, CoordWidth'($urandom),
           StyleWidth'($urandom), FormWidth'($urandom));
   endtask

   task automatic drain();
      pause_req(1);
      while (outstanding != 0) @(negedge clock);
   endtask

   task automatic set_count(input int n);
      drain();
      // writes still walking the chain give no result, so let them finish
      repeat (LATENCY + 3) @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= 3'(4 * REG_SHAPE_COUNT);
      pwdata  <= 32'(n);
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   initial begin : stimulus
      int k;
      int span;
      int px;
      int py;
      int r;
      logic [FormWidth-1:0] f;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // shape_count is still zero after reset, so this pixel must miss
      probe(8'd10, 8'd10);

      set_count(MAX_SHAPES);
      send(REQ_WRITE, 3'd0, 8'd10,  8'd10,  8'd0,   8'hFF, FORM_DIAMOND);
      send(REQ_WRITE, 3'd1, 8'd255, 8'd255, 8'd255, 8'h00, FORM_CIRCLE);
      send(REQ_WRITE, 3'd2, 8'd50,  8'd50,  8'd255, 8'hAA, FORM_OFF);
      send(REQ_WRITE, 3'd3, 8'd0,   8'd255, 8'd255, 8'h55, FORM_DIAMOND);
      send(REQ_WRITE, 3'd4, 8'd128, 8'd128, 8'd0,   8'h11, FORM_CIRCLE);
      send(REQ_WRITE, 3'd5, 8'd200, 8'd20,  8'd255, 8'h33, FORM_RESERVED);
      send(REQ_WRITE, 3'd6, 8'd100, 8'd100, 8'd20,  8'h66, FORM_DIAMOND);
      send(REQ_WRITE, 3'd7, 8'd0,   8'd0,   8'd255, 8'h77, FORM_CIRCLE);
      probe(8'd10,  8'd10);
      probe(8'd11,  8'd10);
      probe(8'd0,   8'd255);
      probe(8'd255, 8'd0);
      probe(8'd255, 8'd255);
      probe(8'd128, 8'd128);
      probe(8'd0,   8'd0);
      probe(8'd200, 8'd20);
      probe(8'd50,  8'd50);
      probe(8'd110, 8'd110);

      // counts above the table size, then a count of zero
      set_count(15);
      probe(8'd200, 8'd20);
      probe(8'd128, 8'd128);
      set_count(MAX_SHAPES + 1);
      probe(8'd0, 8'd0);
      set_count(0);
      probe(8'd10, 8'd10);

      for (int phase = 0; phase < 10; phase++) begin
         case (phase)
            0:       set_count(MAX_SHAPES);
            1:       set_count(15);
            2:       set_count(0);
            default: set_count($urandom_range(0, 15));
         endcase
         quiet = (phase % 4 == 3);
         for (int i = 0; i < 95; i++) begin
            if (!quiet) pause_req(pick_gap());
            // wait mid-phase until every pixel result has been taken
            if (phase % 3 == 1 && i == 47) drain();
            if ($urandom_range(0, 99) < 15) begin
               r = $urandom_range(0, 99);
               if (r < 45) f = FORM_DIAMOND;
               else if (r < 90) f = FORM_CIRCLE;
               else if (r < 95) f = FORM_OFF;
               else f = FORM_RESERVED;
               r = $urandom_range(0, 99);
               if (r < 70) r = $urandom_range(0, 60);
               else if (r < 95) r = $urandom_range(0, 255);
               else r = 0;
               send(REQ_WRITE, SlotWidth'($urandom_range(0, 7)), CoordWidth'($urandom),
                    CoordWidth'($urandom), CoordWidth'(r), StyleWidth'($urandom), f);
            end else if ($urandom_range(0, 99) < 65) begin
               k    = $urandom_range(0, MAX_SHAPES - 1);
               span = int'(placed_r[k]) + 3;
               px   = int'(placed_x[k]) + int'($urandom_range(0, 2 * span)) - span;
               py   = int'(placed_y[k]) + int'($urandom_range(0, 2 * span)) - span;
               if (px < 0) px = 0;
               if (px > 255) px = 255;
               if (py < 0) py = 0;
               if (py > 255) py = 255;
               probe(CoordWidth'(px), CoordWidth'(py));
            end else begin
               probe(CoordWidth'($urandom), CoordWidth'($urandom));
            end
         end
      end
      quiet = 1'b0;

      drain();
      repeat (LATENCY + 5) @(negedge clock);
      if (mismatches == 0) begin
         $display("priority_shape_overlay: match");
      end else begin
         $display("priority_shape_overlay: mismatch");
      end
      $finish;
   end

endmodule

@@ priority_shape_overlay.f @@
rtl/core/pso_pkg.sv
rtl/core/pso_cell.sv
rtl/core/priority_shape_overlay.sv
tb/overlay_checker.sv
tb/tb_top.sv
